/* rtl/core/sng_pkg.sv */
// ----------------------------------------------------------------------------
// sng_pkg: shared types and constants of the stereo noise gate
// Sequencer states, shared multiplier operations, the control group that
// the sequencer hands to the multiply-accumulate unit, and the gain ramp.
// ----------------------------------------------------------------------------
package sng_pkg;

   localparam int CFG_BITS       = 16;
   localparam int GAIN_BITS      = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DRY       = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WET       = 2'd2;

   // Gain is unsigned Q1.15; unity is 32768, and the ramp keeps it between zero and unity.
   localparam logic [GAIN_BITS-1:0] GAIN_ONE  = 16'd32768;
   localparam logic [GAIN_BITS-1:0] GAIN_STEP = 16'd164;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DX,
      ST_WG,
      ST_PX,
      ST_DONE
   } sng_state_type;

   typedef enum logic [1:0] {
      MAC_DX,
      MAC_WG,
      MAC_PX
   } mac_op_type;

   typedef struct packed {
      logic       idle;
      logic       mac_en;
      mac_op_type op;
      logic       chan;
      logic       save_left;
      logic       load_rsp;
   } seq_ctrl_type;

   // One step of the linear gain ramp, saturating at zero and unity.
   function automatic logic [GAIN_BITS-1:0] ramp_gain(input logic [GAIN_BITS-1:0] gain,
                                                      input logic in_band);
      logic [GAIN_BITS-1:0] result;
      if (in_band) begin
         result = (gain < GAIN_STEP) ? '0 : gain - GAIN_STEP;
      end else begin
         result = (gain > GAIN_ONE - GAIN_STEP) ? GAIN_ONE : gain + GAIN_STEP;
      end
      return result;
   endfunction

endpackage

/* rtl/core/sng_mac.sv */
// ----------------------------------------------------------------------------
// sng_mac: shared multiply-accumulate unit
// One signed multiplier builds dry*x*2^15 + wet*gain*x in three products;
// the accumulator is rounded to nearest and saturated to the sample width.
// ----------------------------------------------------------------------------
module sng_mac
   import sng_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  seq_ctrl_type                  ctrl,
   input  logic        [CFG_BITS-1:0]    dry_level,
   input  logic        [CFG_BITS-1:0]    wet_level,
   input  logic        [GAIN_BITS-1:0]   gain,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic signed [SAMPLE_BITS-1:0] result
);

   localparam int MB  = (SAMPLE_BITS > GAIN_BITS + 1) ? SAMPLE_BITS : GAIN_BITS + 1;
   localparam int AB  = 33;
   localparam int PW  = AB + MB;
   localparam int ACW = SAMPLE_BITS + 32;
   localparam int QW  = ACW - 30;

   localparam logic signed [ACW-1:0] RND = {{(ACW-30){1'b0}}, 1'b1, 29'b0};
   localparam logic signed [QW-1:0]  QHI = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [QW-1:0]  QLO = {3'b111, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [AB-1:0]  mul_a;
   logic signed [MB-1:0]  mul_b;
   logic signed [PW-1:0]  prod;
   logic        [31:0]    p1_ff, p1_in;
   logic signed [ACW-1:0] acc_ff, acc_in;
   logic signed [ACW-1:0] rounded;
   logic signed [QW-1:0]  q;

   always_comb begin
      mul_a = AB'(dry_level);
      mul_b = MB'(sample);
      case (ctrl.op)
         MAC_DX: begin
            mul_a = AB'(dry_level);
            mul_b = MB'(sample);
         end
         MAC_WG: begin
            mul_a = AB'(wet_level);
            mul_b = MB'(gain);
         end
         MAC_PX: begin
            mul_a = AB'(p1_ff);
            mul_b = MB'(sample);
         end
         default: begin
            mul_a = AB'(dry_level);
            mul_b = MB'(sample);
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      p1_in  = p1_ff;
      acc_in = acc_ff;
      if (ctrl.mac_en) begin
         case (ctrl.op)
            MAC_DX:  acc_in = {prod[ACW-16:0], 15'b0};
            MAC_WG:  p1_in  = prod[31:0];
            MAC_PX:  acc_in = acc_ff + prod[ACW-1:0];
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      acc_ff <= acc_in;
   end

   // Round to nearest, ties toward plus infinity, then clamp.
   assign rounded = acc_ff + RND;
   assign q       = rounded[ACW-1:30];

   always_comb begin
      if (q > QHI) begin
         result = QHI[SAMPLE_BITS-1:0];
      end else if (q < QLO) begin
         result = QLO[SAMPLE_BITS-1:0];
      end else begin
         result = q[SAMPLE_BITS-1:0];
      end
   end

endmodule

/* rtl/core/sng_seq.sv */
// ----------------------------------------------------------------------------
// sng_seq: frame sequencer
// Steps the shared multiplier through three operations per channel, left
// first, and hands the finished frame to the response register.
// ----------------------------------------------------------------------------
module sng_seq
   import sng_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_fire,
   input  logic         rsp_block,
   output seq_ctrl_type ctrl
);

   sng_state_type state_ff, state_in;
   logic          chan_ff, chan_in;

   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DX;
               chan_in  = 1'b0;
            end
         end
         ST_DX: state_in = ST_WG;
         ST_WG: state_in = ST_PX;
         ST_PX: state_in = ST_DONE;
         ST_DONE: begin
            if (!chan_ff) begin
               state_in = ST_DX;
               chan_in  = 1'b1;
            end else if (!rsp_block) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl           = '0;
      ctrl.chan      = chan_ff;
      ctrl.op        = MAC_DX;
      case (state_ff)
         ST_IDLE: ctrl.idle = 1'b1;
         ST_DX: begin
            ctrl.mac_en = 1'b1;
            ctrl.op     = MAC_DX;
         end
         ST_WG: begin
            ctrl.mac_en = 1'b1;
            ctrl.op     = MAC_WG;
         end
         ST_PX: begin
            ctrl.mac_en = 1'b1;
            ctrl.op     = MAC_PX;
         end
         ST_DONE: begin
            ctrl.save_left = !chan_ff;
            ctrl.load_rsp  = chan_ff && !rsp_block;
         end
         default: ctrl.idle = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

endmodule

/* rtl/core/stereo_noise_gate_top.sv */
// ----------------------------------------------------------------------------
// stereo_noise_gate_top: two-channel noise gate with linear gain ramp
// and dry/wet mix.
//
// Usage: a stereo frame arrives on the req_ stream; the gated, mixed frame
// leaves on the rsp_ stream. On acceptance each channel's gain steps down
// by 164 when the sample lies strictly inside the threshold band, and up
// otherwise; the new gain is used for that frame's output.
// The csr_ channel writes gate_threshold, dry_level and wet_level; it is
// always ready and should only be written while no frame is in flight.
// Sequence: an accepted frame steps through DX, WG, PX and DONE for the left
// channel, then again for the right; the last DONE loads the output register
// that drives rsp_tvalid. A new frame is accepted only back in idle, as the
// single shared multiplier does three products per channel plus one DONE step.
// A finished frame sits in the output register while the next frame is
// accepted and computed; if rsp_tready is still low when that next frame
// finishes, the sequencer waits and holds req_tready low.
// Reset (synchronous) sets gains to unity and clears settings and rsp_tvalid.
// ----------------------------------------------------------------------------
module stereo_noise_gate_top
   import sng_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // Fields from bit 0 up: left_sample, right_sample.
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // Fields from bit 0 up: left_out, right_out.
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data
);

   localparam int TDW = ((2*SAMPLE_BITS+7)/8)*8;
   localparam int CW  = ((SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS) + 2;

   seq_ctrl_type ctrl;
   logic         req_fire;
   logic         rsp_block;

   logic [CFG_BITS-1:0] thr_ff, thr_in;
   logic [CFG_BITS-1:0] dry_ff, dry_in;
   logic [CFG_BITS-1:0] wet_ff, wet_in;

   logic [GAIN_BITS-1:0] gain_l_ff, gain_l_in;
   logic [GAIN_BITS-1:0] gain_r_ff, gain_r_in;

   logic signed [SAMPLE_BITS-1:0] in_left, in_right;
   logic signed [SAMPLE_BITS-1:0] x_l_ff, x_l_in;
   logic signed [SAMPLE_BITS-1:0] x_r_ff, x_r_in;
   logic signed [SAMPLE_BITS-1:0] x_sel;
   logic        [GAIN_BITS-1:0]   gain_sel;
   logic signed [SAMPLE_BITS-1:0] mac_result;

   logic signed [CW-1:0] t_pos, t_neg, xl_ext, xr_ext;
   logic                 inside_l, inside_r;

   logic signed [SAMPLE_BITS-1:0] left_hold_ff, left_hold_in;
   logic signed [SAMPLE_BITS-1:0] out_l_ff, out_l_in;
   logic signed [SAMPLE_BITS-1:0] out_r_ff, out_r_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   assign in_left  = req_tdata[SAMPLE_BITS-1:0];
   assign in_right = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

   assign req_tready = ctrl.idle;
   assign req_fire   = req_tvalid && ctrl.idle;
   assign rsp_block  = rsp_valid_ff && !rsp_tready;
   assign csr_ready  = 1'b1;

   // Band test: strictly between minus and plus threshold.
   assign t_pos    = CW'(thr_ff);
   assign t_neg    = -t_pos;
   assign xl_ext   = CW'(in_left);
   assign xr_ext   = CW'(in_right);
   assign inside_l = (xl_ext < t_pos) && (xl_ext > t_neg);
   assign inside_r = (xr_ext < t_pos) && (xr_ext > t_neg);

   always_comb begin
      thr_in = thr_ff;
      dry_in = dry_ff;
      wet_in = wet_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD: thr_in = csr_data;
            CSR_DRY:       dry_in = csr_data;
            CSR_WET:       wet_in = csr_data;
            default:       thr_in = thr_ff;
         endcase
      end
   end

   always_comb begin
      gain_l_in = gain_l_ff;
      gain_r_in = gain_r_ff;
      x_l_in    = x_l_ff;
      x_r_in    = x_r_ff;
      if (req_fire) begin
         gain_l_in = ramp_gain(gain_l_ff, inside_l);
         gain_r_in = ramp_gain(gain_r_ff, inside_r);
         x_l_in    = in_left;
         x_r_in    = in_right;
      end
   end

   assign x_sel    = ctrl.chan ? x_r_ff : x_l_ff;
   assign gain_sel = ctrl.chan ? gain_r_ff : gain_l_ff;

   always_comb begin
      left_hold_in = ctrl.save_left ? mac_result : left_hold_ff;
      out_l_in     = ctrl.load_rsp ? left_hold_ff : out_l_ff;
      out_r_in     = ctrl.load_rsp ? mac_result : out_r_ff;
      if (ctrl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= '0;
         dry_ff       <= '0;
         wet_ff       <= '0;
         gain_l_ff    <= GAIN_ONE;
         gain_r_ff    <= GAIN_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         dry_ff       <= dry_in;
         wet_ff       <= wet_in;
         gain_l_ff    <= gain_l_in;
         gain_r_ff    <= gain_r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_l_ff       <= x_l_in;
      x_r_ff       <= x_r_in;
      left_hold_ff <= left_hold_in;
      out_l_ff     <= out_l_in;
      out_r_ff     <= out_r_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDW'({out_r_ff, out_l_ff});

   sng_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .rsp_block (rsp_block),
      .ctrl      (ctrl)
   );

   sng_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock     (clock),
      .ctrl      (ctrl),
      .dry_level (dry_ff),
      .wet_level (wet_ff),
      .gain      (gain_sel),
      .sample    (x_sel),
      .result    (mac_result)
   );

endmodule

/* rtl/core/sng_checker.sv */
// ----------------------------------------------------------------------------
// sng_checker: port-level checks of the stereo noise gate
// Watches the top-level streams and flags sequencing slips.
// ----------------------------------------------------------------------------
module sng_checker #(
   parameter int TDW = 32
) (
   input logic           clock,
   input logic           reset,
   input logic           req_tvalid,
   input logic           req_tready,
   input logic           rsp_tvalid,
   input logic           rsp_tready,
   input logic [TDW-1:0] rsp_tdata
);

   // A stalled response transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // The block is busy right after it accepts a frame.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("frame accepted while previous frame in work");

   // A new response only appears at the end of a busy period.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response raised without a frame in work");

   // A frame cannot finish in the cycle after it was accepted.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("response raised too early");

endmodule

bind stereo_noise_gate_top sng_checker #(
   .TDW (((2*SAMPLE_BITS+7)/8)*8)
) u_sng_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/tb_stereo_noise_gate_top.sv */
// ----------------------------------------------------------------------------
// tb_stereo_noise_gate_top: self-checking bench for the stereo noise gate
// Stereo frames are streamed in with random gaps. A scoreboard predicts each
// channel's gain ramp and the rounded, saturated dry/wet mix, and compares
// every output frame against that prediction. The bench steps through
// several register settings, the extremes among them. At one point the
// output side holds off for a long time so that the block stalls its input.
// ----------------------------------------------------------------------------
module tb_stereo_noise_gate_top
   import sng_pkg::*;
();

   localparam int SAMPLE_BITS  = 16;
   localparam int DATA_BITS    = ((2*SAMPLE_BITS+7)/8)*8;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PRESSURE_AT  = 400;
   localparam int HOLD_CYCLES  = 150;
   localparam int PHASES       = 10;
   localparam int PHASE_FRAMES = 148;
   localparam int DRAIN_CYCLES = 12;
   localparam int REPORT_MAX   = 10;

   // Index 3 has no register behind it; writes to it must be ignored.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {
      RUN_QUIET,
      RUN_LOUD,
      RUN_EDGE,
      RUN_NOISE
   } run_kind_type;

   typedef struct {
      logic [SAMPLE_BITS-1:0] left;
      logic [SAMPLE_BITS-1:0] right;
   } gate_frame_type;

   class frame_checker_type;
      logic [CFG_BITS-1:0] threshold;
      logic [CFG_BITS-1:0] dry;
      logic [CFG_BITS-1:0] wet;
      int                  left_gain;
      int                  right_gain;
      gate_frame_type      expected_frames[$];
      int                  errors;

      function new();
         threshold  = '0;
         dry        = '0;
         wet        = '0;
         left_gain  = int'(GAIN_ONE);
         right_gain = int'(GAIN_ONE);
         errors     = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] index, logic [CFG_BITS-1:0] value);
         case (index)
            CSR_THRESHOLD: threshold = value;
            CSR_DRY:       dry = value;
            CSR_WET:       wet = value;
            default: ;
         endcase
      endfunction

      function int next_gain(int gain, int x);
         int t;
         int step;
         int one;
         t    = int'(threshold);
         step = int'(GAIN_STEP);
         one  = int'(GAIN_ONE);
         if (x < t && x > -t) begin
            return (gain < step) ? 0 : gain - step;
         end
         return (gain + step > one) ? one : gain + step;
      endfunction

      function logic [SAMPLE_BITS-1:0] mixed(int x, int gain);
         longint acc;
         longint hi;
         longint lo;
         hi  = (longint'(1) << (SAMPLE_BITS-1)) - 1;
         lo  = -hi - 1;
         acc = longint'(dry) * x * longint'(int'(GAIN_ONE)) + longint'(wet) * x * gain;
         // Arithmetic shift floors, so this rounds half toward plus infinity.
         acc = (acc + (longint'(1) << 29)) >>> 30;
         if (acc > hi) acc = hi;
         if (acc < lo) acc = lo;
         return acc[SAMPLE_BITS-1:0];
      endfunction

      function void predict_frame(logic [DATA_BITS-1:0] data);
         int             xl;
         int             xr;
         gate_frame_type f;
         xl = $signed(data[SAMPLE_BITS-1:0]);
         xr = $signed(data[2*SAMPLE_BITS-1:SAMPLE_BITS]);
         left_gain  = next_gain(left_gain, xl);
         f.left     = mixed(xl, left_gain);
         right_gain = next_gain(right_gain, xr);
         f.right    = mixed(xr, right_gain);
         expected_frames.push_back(f);
      endfunction

      function void check_frame(logic [DATA_BITS-1:0] data);
         gate_frame_type f;
         logic [SAMPLE_BITS-1:0] got_left;
         logic [SAMPLE_BITS-1:0] got_right;
         got_left  = data[SAMPLE_BITS-1:0];
         got_right = data[2*SAMPLE_BITS-1:SAMPLE_BITS];
         if (expected_frames.size() == 0) begin
            if (errors < REPORT_MAX)
               $display("unexpected output frame: left %0d right %0d",
                        $signed(got_left), $signed(got_right));
            errors++;
            return;
         end
         f = expected_frames.pop_front();
         if (got_left !== f.left) begin
            if (errors < REPORT_MAX)
               $display("left_out mismatch: expected %0d, got %0d",
                        $signed(f.left), $signed(got_left));
            errors++;
         end
         if (got_right !== f.right) begin
            if (errors < REPORT_MAX)
               $display("right_out mismatch: expected %0d, got %0d",
                        $signed(f.right), $signed(got_right));
            errors++;
         end
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [DATA_BITS-1:0]      req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [DATA_BITS-1:0]      rsp_tdata;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_data = '0;

   frame_checker_type sb;
   bit                no_idle = 1'b0;
   int                cycle_count = 0;

   run_kind_type run_kind[2];
   int           run_left[2] = '{0, 0};

   int dir_left[21]  = '{0, 32767, -32768, 1, 999, 1000, -1000, -999, -1, 300,
                         10, 10, 10, 10, 10, 10, 32767, -32768, 20000, 1001, 0};
   int dir_right[21] = '{0, -32768, 32767, -1, -999, -1000, 1000, 999, 1, -300,
                         -10, -10, -10, -10, -10, -10, 32767, -32768, -20000, -1001, 32767};

   int cfg_thr[6] = '{0, 65535, 32768, 1, 32767, 2000};
   int cfg_dry[6] = '{65535, 0, 32768, 65535, 0, 32768};
   int cfg_wet[6] = '{65535, 65535, 32768, 0, 32768, 65535};

   stereo_noise_gate_top #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_frame(input int left, input int right);
      int gap;
      logic [SAMPLE_BITS-1:0] l;
      logic [SAMPLE_BITS-1:0] r;
      l   = left[SAMPLE_BITS-1:0];
      r   = right[SAMPLE_BITS-1:0];
      gap = no_idle ? 0 : $urandom_range(4, 0);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {r, l};
      do @(posedge clock); while (!req_tready);
      sb.predict_frame({r, l});
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value[CFG_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, value[CFG_BITS-1:0]);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop offering frames and wait until every predicted frame has come out.
   task automatic drain_frames();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic int draw_sample(run_kind_type kind, int thr);
      int mag;
      int x;
      x = $signed(16'($urandom_range(65535, 0)));
      case (kind)
         RUN_QUIET: begin
            if (thr > 0 && thr <= 32768) begin
               mag = $urandom_range(thr - 1, 0);
               x   = $urandom_range(1, 0) ? -mag : mag;
            end
         end
         RUN_LOUD: begin
            if (thr <= 32768) begin
               mag = $urandom_range(32768, thr);
               if (mag == 32768) x = -32768;
               else x = $urandom_range(1, 0) ? -mag : mag;
            end
         end
         RUN_EDGE: begin
            case ($urandom_range(3, 0))
               0: x = thr;
               1: x = -thr;
               2: x = thr - 1;
               default: x = 1 - thr;
            endcase
            if (x > 32767) x = 32767;
            if (x < -32768) x = -32768;
         end
         default: ;
      endcase
      return x;
   endfunction

   // Each channel follows runs of quiet, loud, edge or noise samples, long enough
   // at times to drive its gain all the way to zero or back to unity.
   function automatic int next_sample(int ch, int thr);
      int pick;
      if (run_left[ch] == 0) begin
         pick = $urandom_range(99, 0);
         if (pick < 40) run_kind[ch] = RUN_QUIET;
         else if (pick < 75) run_kind[ch] = RUN_LOUD;
         else if (pick < 85) run_kind[ch] = RUN_EDGE;
         else run_kind[ch] = RUN_NOISE;
         if ($urandom_range(7, 0) == 0) run_left[ch] = $urandom_range(260, 150);
         else run_left[ch] = $urandom_range(40, 1);
      end
      run_left[ch]--;
      return draw_sample(run_kind[ch], thr);
   endfunction

   initial begin
      int thr;
      int dry;
      int wet;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Registers still at reset: the mix is zero whatever comes in.
      send_frame(12345, -12345);
      send_frame(32767, -32768);
      send_frame(0, 0);
      drain_frames();

      write_csr(CSR_UNUSED, $urandom_range(65535, 0));
      write_csr(CSR_THRESHOLD, 1000);
      write_csr(CSR_DRY, 16384);
      write_csr(CSR_WET, 32768);
      foreach (dir_left[i]) send_frame(dir_left[i], dir_right[i]);

      for (int p = 0; p < PHASES; p++) begin
         drain_frames();
         if (p < 6) begin
            thr = cfg_thr[p];
            dry = cfg_dry[p];
            wet = cfg_wet[p];
         end else begin
            thr = $urandom_range(1, 0) ? $urandom_range(3000, 0) : $urandom_range(32768, 0);
            dry = $urandom_range(65535, 0);
            wet = $urandom_range(65535, 0);
         end
         write_csr(CSR_THRESHOLD, thr);
         write_csr(CSR_DRY, dry);
         write_csr(CSR_WET, wet);
         if (p == 4) write_csr(CSR_UNUSED, $urandom_range(65535, 0));
         no_idle = (p == 2) || ($urandom_range(3, 0) == 0);
         for (int n = 0; n < PHASE_FRAMES; n++) begin
            int l;
            int r;
            l = next_sample(0, thr);
            r = next_sample(1, thr);
            send_frame(l, r);
         end
      end

      drain_frames();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Output side: random back-pressure, plus one long hold-off that lets the
   // block fill up while frames keep being offered.
   initial begin
      int gap;
      int seen;
      bit held;
      seen = 0;
      held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && seen == PRESSURE_AT) begin
            held = 1'b1;
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            gap = no_idle ? 0 : $urandom_range(4, 0);
            repeat (gap) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_frame(rsp_tdata);
         seen++;
      end
   end

endmodule
